// File: rtl/core/multi_adc_capture_scheduler_fifo_top_assert.svh
// assertion macros shared by the port checker
`ifndef MULTI_ADC_CAPTURE_SCHEDULER_FIFO_TOP_ASSERT_SVH
`define MULTI_ADC_CAPTURE_SCHEDULER_FIFO_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define MACSF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("capture scheduler port check failed");

// next-cycle implication, disabled in reset
`define MACSF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("capture scheduler port check failed");

`endif

// File: rtl/core/macsf_pkg.sv
// shared types and constants of the capture scheduler
`default_nettype none
package macsf_pkg;

   localparam int NumPorts = 3;

   // port numbers
   localparam int PortMain   = 0;
   localparam int PortSecond = 1;
   localparam int PortThird  = 2;

   // operation codes
   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_DONE = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_ENABLE_MASK  = 2'd0;
   localparam logic [1:0] CSR_MIN_CYCLE    = 2'd1;
   localparam logic [1:0] CSR_DIVIDE_RATIO = 2'd2;

   // register reset values
   localparam logic [2:0]  EnableMaskReset  = 3'd7;
   localparam logic [15:0] MinCycleReset    = 16'd2;
   localparam logic [15:0] DivideRatioReset = 16'd100;

   // command queue geometry
   localparam int QueueDepth = 2;

   typedef logic [NumPorts-1:0] port_mask_type;

   typedef struct packed {
      logic [63:0] high;
      logic [63:0] low;
   } sample_word_type;

   // classified command from the front end to the back end
   typedef struct packed {
      port_mask_type   start_mask;
      port_mask_type   push_mask;
      logic            read_en;
      logic [1:0]      read_port;
      sample_word_type word_a;
      sample_word_type word_b;
   } cmd_type;

endpackage
`default_nettype wire

// File: rtl/core/macsf_front.sv
// front end: config registers, divider and ready edge detect, command build
`default_nettype none
module macsf_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [1:0]       req_op,
   input  logic [1:0]       req_read_port,
   input  logic             req_ready_second,
   input  logic             req_ready_third,
   input  logic [63:0]      req_samples_a_lo,
   input  logic [63:0]      req_samples_a_hi,
   input  logic [63:0]      req_samples_b_lo,
   input  logic [63:0]      req_samples_b_hi,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_data,
   input  logic             q_full,
   output logic             q_push,
   output macsf_pkg::cmd_type q_cmd
);
   import macsf_pkg::*;

   logic [2:0]  enable_mask_ff;
   logic [15:0] min_cycle_ff;
   logic [15:0] divide_ratio_ff;
   logic [15:0] divide_count_ff, divide_count_in;
   logic        prev_second_ff, prev_second_in;
   logic        prev_third_ff, prev_third_in;
   logic        accept;

   // handshake
   assign busy      = reset | q_full;
   assign csr_ready = ~reset;
   assign accept    = start & ~busy;
   assign q_push    = accept;

   // classify the item and work out the scheduler state update
   always_comb begin
      prev_second_in  = prev_second_ff;
      prev_third_in   = prev_third_ff;
      divide_count_in = divide_count_ff;
      q_cmd           = '0;
      q_cmd.read_port = req_read_port;
      q_cmd.word_a    = '{high: req_samples_a_hi, low: req_samples_a_lo};
      q_cmd.word_b    = '{high: req_samples_b_hi, low: req_samples_b_lo};
      case (req_op)
         OP_TICK: begin
            q_cmd.start_mask[PortMain] = enable_mask_ff[PortMain];
            if (divide_count_ff == 16'd1) begin
               q_cmd.start_mask[PortSecond] = enable_mask_ff[PortSecond];
               q_cmd.start_mask[PortThird]  = enable_mask_ff[PortThird];
               prev_second_in = 1'b1;
               prev_third_in  = 1'b1;
            end else if (divide_count_ff >= min_cycle_ff) begin
               if (enable_mask_ff[PortSecond]) begin
                  q_cmd.push_mask[PortSecond] = req_ready_second & ~prev_second_ff;
                  prev_second_in = req_ready_second;
               end
               if (enable_mask_ff[PortThird]) begin
                  q_cmd.push_mask[PortThird] = req_ready_third & ~prev_third_ff;
                  prev_third_in = req_ready_third;
               end
            end else begin
               if (enable_mask_ff[PortSecond] && !req_ready_second) begin
                  prev_second_in = 1'b0;
               end
               if (enable_mask_ff[PortThird] && !req_ready_third) begin
                  prev_third_in = 1'b0;
               end
            end
            divide_count_in = (divide_count_ff == divide_ratio_ff) ? 16'd1
                                                                  : divide_count_ff + 16'd1;
         end
         OP_DONE: begin
            q_cmd.push_mask[PortMain] = 1'b1;
         end
         OP_READ: begin
            q_cmd.read_en = (req_read_port < 2'(NumPorts));
         end
         default: begin
         end
      endcase
   end

   // config registers and scheduler state
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_mask_ff  <= EnableMaskReset;
         min_cycle_ff    <= MinCycleReset;
         divide_ratio_ff <= DivideRatioReset;
         divide_count_ff <= 16'd1;
         prev_second_ff  <= 1'b0;
         prev_third_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_ENABLE_MASK:  enable_mask_ff  <= csr_data[2:0];
               CSR_MIN_CYCLE:    min_cycle_ff    <= csr_data;
               CSR_DIVIDE_RATIO: divide_ratio_ff <= csr_data;
               default: begin
               end
            endcase
         end
         if (accept) begin
            divide_count_ff <= divide_count_in;
            prev_second_ff  <= prev_second_in;
            prev_third_ff   <= prev_third_in;
         end
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/macsf_queue.sv
// two-entry command queue between front end and back end
`default_nettype none
module macsf_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  macsf_pkg::cmd_type cmd_wr,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output macsf_pkg::cmd_type cmd_rd
);
   import macsf_pkg::*;

   localparam int PtrWidth   = $clog2(QueueDepth);
   localparam int CountWidth = $clog2(QueueDepth + 1);

   cmd_type                entry_ff [QueueDepth];
   logic [PtrWidth-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CountWidth-1:0]  count_ff;

   assign full   = (count_ff == CountWidth'(QueueDepth));
   assign empty  = (count_ff == '0);
   assign cmd_rd = entry_ff[rd_ptr_ff];

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cmd_wr;
      end
   end

   // pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/macsf_back.sv
// back end: per-port ring fifos with overwrite, pops and the response register
`default_nettype none
module macsf_back #(
   parameter int FIFO_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  macsf_pkg::cmd_type q_cmd,
   output logic               q_pop,
   output logic               rsp_valid,
   output logic [2:0]         rsp_start_mask,
   output logic [2:0]         rsp_captured_mask,
   output logic [2:0]         rsp_full_mask,
   output logic               rsp_read_ok,
   output logic [63:0]        rsp_read_low,
   output logic [63:0]        rsp_read_high
);
   import macsf_pkg::*;

   localparam int PtrWidth   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CountWidth = $clog2(FIFO_DEPTH + 1);

   logic                  exec;
   port_mask_type         push, pop;
   sample_word_type       wr_word [NumPorts];
   logic [PtrWidth-1:0]   wr_ptr_ff [NumPorts];
   logic [PtrWidth-1:0]   wr_ptr_in [NumPorts];
   logic [PtrWidth-1:0]   rd_ptr_ff [NumPorts];
   logic [PtrWidth-1:0]   rd_ptr_in [NumPorts];
   logic [CountWidth-1:0] count_ff  [NumPorts];
   logic [CountWidth-1:0] count_in  [NumPorts];
   port_mask_type         full_ff, full_in;
   sample_word_type       rd_word_ff [NumPorts];
   logic                  valid_ff;
   port_mask_type         start_mask_ff, captured_ff;
   logic                  read_ok_ff;
   logic [1:0]            read_sel_ff;
   sample_word_type       read_word;

   // one command per cycle
   assign exec  = ~q_empty;
   assign q_pop = exec;

   // pointer, count and full flag updates
   always_comb begin
      for (int p = 0; p < NumPorts; p++) begin
         wr_word[p] = (p == PortThird) ? q_cmd.word_b : q_cmd.word_a;
         push[p]    = exec & q_cmd.push_mask[p];
         pop[p]     = exec & q_cmd.read_en & (q_cmd.read_port == 2'(p))
                      & (count_ff[p] != '0);
         wr_ptr_in[p] = wr_ptr_ff[p];
         rd_ptr_in[p] = rd_ptr_ff[p];
         count_in[p]  = count_ff[p];
         full_in[p]   = full_ff[p];
         if (push[p]) begin
            wr_ptr_in[p] = (wr_ptr_ff[p] == PtrWidth'(FIFO_DEPTH - 1)) ? '0
                                                                     : wr_ptr_ff[p] + 1'b1;
            if (count_ff[p] < CountWidth'(FIFO_DEPTH)) begin
               count_in[p] = count_ff[p] + 1'b1;
               full_in[p]  = 1'b0;
            end else begin
               full_in[p]  = 1'b1;
            end
         end else if (pop[p]) begin
            rd_ptr_in[p] = (rd_ptr_ff[p] == PtrWidth'(FIFO_DEPTH - 1)) ? '0
                                                                     : rd_ptr_ff[p] + 1'b1;
            count_in[p]  = count_ff[p] - 1'b1;
         end
      end
   end

   // sample storage, one memory per port
   for (genvar gp = 0; gp < NumPorts; gp++) begin : g_port
      sample_word_type entry_mem [FIFO_DEPTH];

      always_ff @(posedge clock) begin
         if (push[gp]) begin
            entry_mem[wr_ptr_ff[gp]] <= wr_word[gp];
         end
         if (pop[gp]) begin
            rd_word_ff[gp] <= entry_mem[rd_ptr_ff[gp]];
         end
      end
   end

   // fifo control state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NumPorts; p++) begin
            wr_ptr_ff[p] <= '0;
            rd_ptr_ff[p] <= '0;
            count_ff[p]  <= '0;
         end
         full_ff <= '0;
      end else begin
         for (int p = 0; p < NumPorts; p++) begin
            wr_ptr_ff[p] <= wr_ptr_in[p];
            rd_ptr_ff[p] <= rd_ptr_in[p];
            count_ff[p]  <= count_in[p];
         end
         full_ff <= full_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         read_ok_ff <= 1'b0;
      end else begin
         valid_ff   <= exec;
         read_ok_ff <= |pop;
      end
   end

   always_ff @(posedge clock) begin
      start_mask_ff <= q_cmd.start_mask;
      captured_ff   <= q_cmd.push_mask;
      read_sel_ff   <= q_cmd.read_port;
   end

   // read data is zero unless an entry came out
   always_comb begin
      read_word = '0;
      if (read_ok_ff) begin
         read_word = rd_word_ff[read_sel_ff];
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_start_mask    = start_mask_ff;
   assign rsp_captured_mask = captured_ff;
   assign rsp_full_mask     = full_ff;
   assign rsp_read_ok       = read_ok_ff;
   assign rsp_read_low      = read_word.low;
   assign rsp_read_high     = read_word.high;

endmodule
`default_nettype wire

// File: rtl/core/multi_adc_capture_scheduler_fifo_top.sv
// top level of the three-port capture scheduler with ring fifos
//
//   channel  ports            handshake            payload
//   request  start, busy      start & !busy        req_op .. req_samples_b_hi
//   response rsp_valid        one-cycle strobe     rsp_start_mask .. rsp_read_high
//   control  csr_valid/ready  csr_valid & ready    csr_index, csr_data
//
// each transaction is answered by one response, registered in the command queue and then in the response register
// front end takes one transaction per cycle unless busy, back end retires one per cycle
// busy is high in reset and while the two-entry command queue is full
// reset is synchronous; fifo sample memories are not cleared, pointers and flags are
// the response side has no back pressure: a strobe is taken in the cycle it shows
`default_nettype none
module multi_adc_capture_scheduler_fifo_top #(
   parameter int FIFO_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [1:0]  req_read_port,
   input  logic        req_ready_second,
   input  logic        req_ready_third,
   input  logic [63:0] req_samples_a_lo,
   input  logic [63:0] req_samples_a_hi,
   input  logic [63:0] req_samples_b_lo,
   input  logic [63:0] req_samples_b_hi,
   output logic        rsp_valid,
   output logic [2:0]  rsp_start_mask,
   output logic [2:0]  rsp_captured_mask,
   output logic [2:0]  rsp_full_mask,
   output logic        rsp_read_ok,
   output logic [63:0] rsp_read_low,
   output logic [63:0] rsp_read_high,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import macsf_pkg::*;

   cmd_type q_wr_cmd, q_rd_cmd;
   logic    q_push, q_full, q_pop, q_empty;

   // front end
   macsf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_read_port    (req_read_port),
      .req_ready_second (req_ready_second),
      .req_ready_third  (req_ready_third),
      .req_samples_a_lo (req_samples_a_lo),
      .req_samples_a_hi (req_samples_a_hi),
      .req_samples_b_lo (req_samples_b_lo),
      .req_samples_b_hi (req_samples_b_hi),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_cmd            (q_wr_cmd)
   );

   // command queue
   macsf_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .cmd_wr (q_wr_cmd),
      .full   (q_full),
      .pop    (q_pop),
      .empty  (q_empty),
      .cmd_rd (q_rd_cmd)
   );

   // back end
   macsf_back #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_cmd             (q_rd_cmd),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_start_mask    (rsp_start_mask),
      .rsp_captured_mask (rsp_captured_mask),
      .rsp_full_mask     (rsp_full_mask),
      .rsp_read_ok       (rsp_read_ok),
      .rsp_read_low      (rsp_read_low),
      .rsp_read_high     (rsp_read_high)
   );

endmodule
`default_nettype wire

// File: rtl/core/macsf_checker.sv
// port-level checker for the capture scheduler, bound to the top level
`default_nettype none
`include "multi_adc_capture_scheduler_fifo_top_assert.svh"
module macsf_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [2:0]  rsp_captured_mask,
   input logic [2:0]  rsp_full_mask,
   input logic        rsp_read_ok,
   input logic [63:0] rsp_read_low,
   input logic [63:0] rsp_read_high
);

   logic       accept;
   logic       read_zero;
   logic [2:0] full_prev_ff;
   logic [2:0] full_change;

   // request handshake and response data helpers
   assign accept      = start & ~busy;
   assign read_zero   = (rsp_read_low == 64'd0) && (rsp_read_high == 64'd0);
   assign full_change = (rsp_full_mask ^ full_prev_ff) & ~rsp_captured_mask;

   // full flags seen in the previous cycle
   always_ff @(posedge clock) begin
      full_prev_ff <= rsp_full_mask;
   end

   // every accepted transaction gets its strobe through the command queue and the response register
   `MACSF_ASSERT_SAME(a_accept_rsp, clock, reset, $past(accept, 2) && $past(!reset), rsp_valid)

   // no strobe without an earlier transaction
   `MACSF_ASSERT_SAME(a_rsp_has_accept, clock, reset, rsp_valid, $past(accept, 2))

   // failed or absent read returns zero data
   `MACSF_ASSERT_SAME(a_empty_read_zero, clock, reset, rsp_valid && !rsp_read_ok, read_zero)

   // full flags only move on ports that captured
   `MACSF_ASSERT_NEXT(a_full_on_push, clock, reset, rsp_valid, !rsp_valid || full_change == 3'd0)

endmodule

bind multi_adc_capture_scheduler_fifo_top macsf_checker u_checker (.*);
`default_nettype wire
